@@ hdl/gcd_lcm_unit_core_assert.svh @@
// Assertion macros used by the gcd/lcm unit core.
`ifndef GCD_LCM_UNIT_CORE_ASSERT_SVH
`define GCD_LCM_UNIT_CORE_ASSERT_SVH

// Implication checked on every rising clock edge while reset is released.
`define GCLU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked while reset is released.
`define GCLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gclu_pkg.sv @@
// Package with the shared constants and sequencer states of the gcd/lcm unit.
package gclu_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_UNSHIFT,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } gclu_state_e;

endpackage

@@ hdl/gclu_addsub.sv @@
// Shared adder/subtractor used by the gcd, division and multiply steps of the sequencer.
module gclu_addsub
  import gclu_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic [OPERAND_WIDTH:0] op_a_i,
  input  logic [OPERAND_WIDTH:0] op_b_i,
  input  logic                   sub_i,
  output logic [OPERAND_WIDTH:0] sum_o,
  output logic                   carry_o
);

  logic [OPERAND_WIDTH+1:0] full;

  // For a subtraction the carry out is high when no borrow occurred.
  assign full = {1'b0, op_a_i} + {1'b0, op_b_i ^ {(OPERAND_WIDTH+1){sub_i}}}
              + (OPERAND_WIDTH+2)'(sub_i);
  assign sum_o   = full[OPERAND_WIDTH:0];
  assign carry_o = full[OPERAND_WIDTH+1];

endmodule

@@ hdl/gcd_lcm_unit_core.sv @@
// Top level of the gcd/lcm unit: sequencer, working registers and stream ports.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tdata: operand_a, operand_b
//  m_axis   | out       | tdata: divisor, multiple; tuser: status
//
// A request runs through the binary gcd steps (a swap of the operands takes
// a step of its own), the restoring of the common power of two, the
// restoring division and the shift-add multiply; the gcd, division and
// multiply steps all use the one shared adder. A zero operand skips these
// steps and goes straight to the result.
// Reset clears the sequencer and the output valid flag. A stalled result
// holds in the output register; the next request may be accepted meanwhile.
module gcd_lcm_unit_core
  import gclu_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF,
  localparam int unsigned InDataW  = ((2 * OPERAND_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((3 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // operand_a, operand_b, zero pad
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // divisor, multiple, zero pad
  output logic                m_axis_tuser    // status
);

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CntW = $clog2(W);

  gclu_state_e state_q, state_d;

  logic [W-1:0]    x_q, x_d;
  logic [W-1:0]    y_q, y_d;
  logic [W-1:0]    a_q, a_d;
  logic [W-1:0]    b_q, b_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    hi_q, hi_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            err_q, err_d;

  logic            m_valid_q, m_valid_d;
  logic [W-1:0]    div_out_q, div_out_d;
  logic [2*W-1:0]  mult_out_q, mult_out_d;
  logic            user_q, user_d;

  logic [W:0]      alu_a, alu_b, alu_sum, rem_sh, mul_s;
  logic            alu_sub, alu_carry;
  logic [W-1:0]    in_a, in_b;
  logic            accept;

  assign in_a   = s_axis_tdata[W-1:0];
  assign in_b   = s_axis_tdata[2*W-1:W];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign rem_sh = {rem_q, a_q[W-1]};

  gclu_addsub #(
    .OPERAND_WIDTH(W)
  ) u_addsub (
    .op_a_i (alu_a),
    .op_b_i (alu_b),
    .sub_i  (alu_sub),
    .sum_o  (alu_sum),
    .carry_o(alu_carry)
  );

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = {1'b0, x_q};
    alu_b   = {1'b0, y_q};
    alu_sub = 1'b1;
    unique case (state_q)
      ST_DIV: begin
        alu_a = rem_sh;
      end
      ST_MUL: begin
        alu_a   = {1'b0, hi_q};
        alu_b   = {1'b0, b_q};
        alu_sub = 1'b0;
      end
      default: ;
    endcase
  end

  assign mul_s = a_q[0] ? alu_sum : {1'b0, hi_q};

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    y_d        = y_q;
    a_d        = a_q;
    b_d        = b_q;
    rem_d      = rem_q;
    hi_d       = hi_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    err_d      = err_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    div_out_d  = div_out_q;
    mult_out_d = mult_out_q;
    user_d     = user_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          x_d   = in_a;
          y_d   = in_b;
          a_d   = in_a;
          b_d   = in_b;
          k_d   = '0;
          err_d = (in_a == '0) || (in_b == '0);
          state_d = err_d ? ST_FIN : ST_GCD;
        end
      end
      ST_GCD: begin
        // Binary gcd; once the common factors of two are gone and y is odd, y stays odd.
        if (x_q == '0) begin
          state_d = ST_UNSHIFT;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + CntW'(1);
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (alu_carry) begin
          x_d = alu_sum[W:1];
        end else begin
          x_d = y_q;
          y_d = x_q;
        end
      end
      ST_UNSHIFT: begin
        if (k_q == '0) begin
          rem_d   = '0;
          cnt_d   = CntW'(W - 1);
          state_d = ST_DIV;
        end else begin
          y_d = y_q << 1;
          k_d = k_q - CntW'(1);
        end
      end
      ST_DIV: begin
        // Restoring division of operand_a by the divisor; quotient bits
        // shift into a_q as the dividend bits leave it.
        a_d   = {a_q[W-2:0], alu_carry};
        rem_d = alu_carry ? alu_sum[W-1:0] : rem_sh[W-1:0];
        if (cnt_q == '0) begin
          hi_d    = '0;
          cnt_d   = CntW'(W - 1);
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      ST_MUL: begin
        hi_d = mul_s[W:1];
        a_d  = {mul_s[0], a_q[W-1:1]};
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          div_out_d  = err_q ? '0 : y_q;
          mult_out_d = err_q ? '0 : {hi_q, a_q};
          user_d     = err_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    a_q        <= a_d;
    b_q        <= b_d;
    rem_q      <= rem_d;
    hi_q       <= hi_d;
    k_q        <= k_d;
    cnt_q      <= cnt_d;
    err_q      <= err_d;
    div_out_q  <= div_out_d;
    mult_out_q <= mult_out_d;
    user_q     <= user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutDataW'({mult_out_q, div_out_q});
  assign m_axis_tuser  = user_q;

`include "gcd_lcm_unit_core_assert.svh"

  `GCLU_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, accept,
                    state_q != ST_IDLE, "idle after request")
  `GCLU_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                    m_axis_tdata == '0, "error result not zero")
  `GCLU_ASSERT_IMPL(a_ok_div_nonzero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
                    div_out_q != '0, "zero divisor")
  `GCLU_ASSERT_IMPL(a_gcd_y_nonzero, clk_i, rst_ni, state_q == ST_GCD,
                    y_q != '0, "gcd operand lost")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the gcd/lcm unit: table-driven and random operand pairs.
module tb_top
  import gclu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OW        = OPERAND_WIDTH_DEF;
  localparam int unsigned IN_W      = ((2 * OW + 7) / 8) * 8;
  localparam int unsigned OUT_W     = ((3 * OW + 7) / 8) * 8;
  localparam int unsigned OP_MAX    = (1 << OW) - 1;
  localparam int unsigned RANDOM_PAIRS = 1650;
  localparam int unsigned CALM_TAIL = 200;
  localparam int unsigned DRAIN_CYCLES = 5 * OW + 20;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  localparam logic STATUS_OK           = 1'b0;
  localparam logic STATUS_ZERO_OPERAND = 1'b1;

  typedef struct packed {
    logic [OW-1:0]   divisor;
    logic [2*OW-1:0] multiple;
    logic            status;
  } gcd_lcm_result_t;

  typedef struct packed {
    logic [OW-1:0]   a;
    logic [OW-1:0]   b;
    bit              typed;
    gcd_lcm_result_t res;
  } pair_row_t;

  localparam int unsigned NUM_ROWS = 22;

  // Rows with typed = 1 carry their expected result; the others use the predictor.
  localparam pair_row_t PAIR_TABLE [NUM_ROWS] = '{
    '{16'd0,     16'd0,     1'b1, '{16'd0,     32'd0,          STATUS_ZERO_OPERAND}},
    '{16'd0,     16'd1,     1'b1, '{16'd0,     32'd0,          STATUS_ZERO_OPERAND}},
    '{16'd1,     16'd0,     1'b1, '{16'd0,     32'd0,          STATUS_ZERO_OPERAND}},
    '{16'd0,     16'd65535, 1'b1, '{16'd0,     32'd0,          STATUS_ZERO_OPERAND}},
    '{16'd65535, 16'd0,     1'b1, '{16'd0,     32'd0,          STATUS_ZERO_OPERAND}},
    '{16'd1,     16'd1,     1'b1, '{16'd1,     32'd1,          STATUS_OK}},
    '{16'd65535, 16'd65535, 1'b1, '{16'd65535, 32'd65535,      STATUS_OK}},
    '{16'd1,     16'd65535, 1'b1, '{16'd1,     32'd65535,      STATUS_OK}},
    '{16'd65535, 16'd1,     1'b1, '{16'd1,     32'd65535,      STATUS_OK}},
    '{16'd65535, 16'd65534, 1'b1, '{16'd1,     32'd4294770690, STATUS_OK}},
    '{16'd32768, 16'd32768, 1'b1, '{16'd32768, 32'd32768,      STATUS_OK}},
    '{16'd1234,  16'd1234,  1'b1, '{16'd1234,  32'd1234,       STATUS_OK}},
    '{16'd2,     16'd3,     1'b1, '{16'd1,     32'd6,          STATUS_OK}},
    '{16'd12,    16'd18,    1'b0, '0},
    '{16'd65521, 16'd65519, 1'b0, '0},
    '{16'd32768, 16'd16384, 1'b0, '0},
    '{16'd49152, 16'd40960, 1'b0, '0},
    '{16'hAAAA,  16'h5555,  1'b0, '0},
    '{16'h5555,  16'hAAAA,  1'b0, '0},
    '{16'd46368, 16'd28657, 1'b0, '0},
    '{16'd1,     16'd32768, 1'b0, '0},
    '{16'd65534, 16'd65535, 1'b0, '0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  gcd_lcm_result_t  pending_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;
  bit               tx_idle_on = 1'b1;
  bit               rx_idle_on = 1'b1;

  gcd_lcm_unit_core #(
    .OPERAND_WIDTH(OW)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Euclid by remainder; the multiple is (a / gcd) * b at double width.
  function automatic gcd_lcm_result_t predict_gcd_lcm(logic [OW-1:0] a, logic [OW-1:0] b);
    gcd_lcm_result_t r;
    logic [OW-1:0]   x;
    logic [OW-1:0]   y;
    logic [OW-1:0]   rem;
    logic [2*OW-1:0] quot;
    r = '0;
    if (a == '0 || b == '0) begin
      r.status = STATUS_ZERO_OPERAND;
      return r;
    end
    x = a;
    y = b;
    while (y != '0) begin
      rem = x % y;
      x = y;
      y = rem;
    end
    quot = {{OW{1'b0}}, a / x};
    r.divisor  = x;
    r.multiple = quot * {{OW{1'b0}}, b};
    r.status   = STATUS_OK;
    return r;
  endfunction

  // Presents one pair, waits for the request to be taken, then maybe leaves a gap.
  task automatic send_pair(input logic [OW-1:0] a, input logic [OW-1:0] b,
                           input bit typed, input gcd_lcm_result_t typed_res);
    s_axis_tdata  <= IN_W'({b, a});
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(typed ? typed_res : predict_gcd_lcm(a, b));
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Picks an operand pair from a mix of shapes that stress the different gcd paths.
  task automatic pick_pair(output logic [OW-1:0] a, output logic [OW-1:0] b);
    int unsigned kind;
    int unsigned g;
    int unsigned k;
    int unsigned x;
    int unsigned y;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      x = $urandom;
      y = $urandom;
    end else if (kind < 50) begin
      g = $urandom_range(1, 255);
      x = g * $urandom_range(1, OP_MAX / g);
      y = g * $urandom_range(1, OP_MAX / g);
    end else if (kind < 60) begin
      // A shared power of two exercises the restoring shifts of a binary gcd.
      k = $urandom_range(0, OW - 1);
      x = $urandom << k;
      y = $urandom << k;
    end else if (kind < 70) begin
      x = $urandom_range(0, 40);
      y = $urandom_range(0, 40);
    end else if (kind < 75) begin
      x = $urandom;
      y = x;
    end else if (kind < 80) begin
      x = $urandom_range(0, 1) ? 0 : $urandom;
      y = (x != 0 || $urandom_range(0, 1)) ? 0 : $urandom;
    end else if (kind < 90) begin
      g = $urandom_range(1, 255);
      x = g;
      y = g * $urandom_range(1, OP_MAX / g);
      if ($urandom_range(0, 1)) begin
        x = y;
        y = g;
      end
    end else begin
      x = OP_MAX - $urandom_range(0, 64);
      y = $urandom_range(0, 1) ? OP_MAX - $urandom_range(0, 64) : $urandom;
    end
    a = x[OW-1:0];
    b = y[OW-1:0];
  endtask

  initial begin
    logic [OW-1:0] a;
    logic [OW-1:0] b;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PAIR_TABLE[i]) begin
      send_pair(PAIR_TABLE[i].a, PAIR_TABLE[i].b, PAIR_TABLE[i].typed, PAIR_TABLE[i].res);
    end

    for (int unsigned i = 0; i < RANDOM_PAIRS; i++) begin
      if (i >= RANDOM_PAIRS - CALM_TAIL) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else if (i % 100 == 0) begin
        tx_idle_on = 1'($urandom_range(0, 1));
        rx_idle_on = 1'($urandom_range(0, 1));
      end
      pick_pair(a, b);
      send_pair(a, b, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: ready drops for random bursts while stalling is enabled.
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    gcd_lcm_result_t got;
    gcd_lcm_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.divisor  = m_axis_tdata[OW-1:0];
      got.multiple = m_axis_tdata[3*OW-1:OW];
      got.status   = m_axis_tuser;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result divisor=%0d multiple=%0d status=%0b",
                 $time, got.divisor, got.multiple, got.status);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (got.divisor !== want.divisor) begin
          $display("%0t: divisor expected %0d actual %0d", $time, want.divisor, got.divisor);
          mismatch_count = mismatch_count + 1;
        end
        if (got.multiple !== want.multiple) begin
          $display("%0t: multiple expected %0d actual %0d",
                   $time, want.multiple, got.multiple);
          mismatch_count = mismatch_count + 1;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/gclu_pkg.sv
hdl/gclu_addsub.sv
hdl/gcd_lcm_unit_core.sv
tb/tb_top.sv
